@@ sv/zcsd_pkg.sv @@
// Package for the zero-cross synchronized sense debouncer.
// Holds the register map, reset values and the configuration bundle type.
// No dependencies; compile first.
`default_nettype none

package zcsd_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [CntW-1:0] SettleReset   = 16'd95;
  localparam logic [CntW-1:0] DebounceReset = 16'd10;

  typedef enum logic [1:0] {
    REG_SETTLE    = 2'd0,
    REG_EXTRACTOR = 2'd1,
    REG_STAND     = 2'd2,
    REG_CARTRIDGE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CntW-1:0] settle_ticks;
    logic [CntW-1:0] extractor_debounce;
    logic [CntW-1:0] stand_debounce;
    logic [CntW-1:0] cartridge_debounce;
  } cfg_t;

endpackage

`default_nettype wire

@@ sv/zcsd_if.sv @@
// Valid/ready channel interfaces for the sense debouncer: one for ticks
// coming in, one for results going out. Depends on nothing.
`default_nettype none

interface zcsd_in_if;
  logic valid;
  logic ready;
  logic zero_cross;
  logic triac_on;
  logic extractor_pin;
  logic stand_pin;
  logic cartridge_pin;

  modport source (output valid, zero_cross, triac_on, extractor_pin, stand_pin,
                  cartridge_pin, input ready);
  modport sink (input valid, zero_cross, triac_on, extractor_pin, stand_pin,
                cartridge_pin, output ready);
endinterface

interface zcsd_out_if;
  logic       valid;
  logic       ready;
  logic       extractor_flag;
  logic       stand_flag;
  logic       cartridge_flag;
  logic       measure_enable;
  logic       detect_strobe;
  logic [1:0] phase_out;

  modport source (output valid, extractor_flag, stand_flag, cartridge_flag,
                  measure_enable, detect_strobe, phase_out, input ready);
  modport sink (input valid, extractor_flag, stand_flag, cartridge_flag,
                measure_enable, detect_strobe, phase_out, output ready);
endinterface

`default_nettype wire

@@ sv/zcsd_regs.sv @@
// APB-style configuration registers of the sense debouncer.
// Depends on zcsd_pkg for the register map and the cfg_t bundle.
`default_nettype none

module zcsd_regs
  import zcsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [AddrW-1:0] cfg_paddr,
  input  wire logic [DataW-1:0] cfg_pwdata,
  output logic      [DataW-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks       <= SettleReset;
      cfg_r.extractor_debounce <= DebounceReset;
      cfg_r.stand_debounce     <= DebounceReset;
      cfg_r.cartridge_debounce <= DebounceReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_SETTLE:    cfg_r.settle_ticks       <= cfg_pwdata[CntW-1:0];
        REG_EXTRACTOR: cfg_r.extractor_debounce <= cfg_pwdata[CntW-1:0];
        REG_STAND:     cfg_r.stand_debounce     <= cfg_pwdata[CntW-1:0];
        REG_CARTRIDGE: cfg_r.cartridge_debounce <= cfg_pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SETTLE:    cfg_prdata = {{(DataW-CntW){1'b0}}, cfg_r.settle_ticks};
      REG_EXTRACTOR: cfg_prdata = {{(DataW-CntW){1'b0}}, cfg_r.extractor_debounce};
      REG_STAND:     cfg_prdata = {{(DataW-CntW){1'b0}}, cfg_r.stand_debounce};
      REG_CARTRIDGE: cfg_prdata = {{(DataW-CntW){1'b0}}, cfg_r.cartridge_debounce};
      default:       cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/zero_cross_synced_sense_debounce.sv @@
// Top level of the zero-cross synchronized sense debouncer.
// Depends on zcsd_pkg, the channel interfaces in zcsd_if and zcsd_regs.
`default_nettype none

// Every transfer on the input channel is one scheduler tick and produces
// exactly one result transfer. A tick is captured in an input register;
// when the result slot is free or is being taken, the sequencer and, on a
// sense tick, the three debounce counters are updated from it and the new
// flags, drive levels and phase are presented on the output channel. One
// tick can be taken every clock cycle while the sink accepts every result: the
// only loop is the sequencer state update, whose registers double as the
// result register. While a result is held back by the sink, the captured
// tick waits in the input register and the input channel stalls only when
// both are full. The sequencer waits for a zero crossing with the triac
// off, counts down settle_ticks, drops measure enable and raises the
// detect strobe, then samples the active-low sense lines on the next tick.
// Each flag sets after its debounce register's count of consecutive active
// samples and clears on the first inactive one. Registers are written over
// the APB-style port at byte addresses 0, 4, 8 and 12; a new value is used
// at the next load of the matching counter, running counts are untouched.
// Configure only while no tick is in flight.

module zero_cross_synced_sense_debounce
  import zcsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  zcsd_in_if.sink               in_ch,
  zcsd_out_if.source            out_ch,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [AddrW-1:0] cfg_paddr,
  input  wire logic [DataW-1:0] cfg_pwdata,
  output logic      [DataW-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [1:0] {
    PH_INIT   = 2'd0,
    PH_AWAIT  = 2'd1,
    PH_SETTLE = 2'd2,
    PH_SENSE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            flag;
  } deb_t;

  // One debounce step: an active sample counts down and sets the flag with a
  // reload when the count reaches zero; an inactive sample clears and reloads.
  function automatic deb_t debounce(input logic active, input logic [CntW-1:0] cnt,
                                    input logic [CntW-1:0] reload, input logic flag);
    deb_t            res;
    logic [CntW-1:0] dec;
    dec = cnt - 1'b1;
    if (active) begin
      if (dec == '0) begin
        res.cnt  = reload;
        res.flag = 1'b1;
      end else begin
        res.cnt  = dec;
        res.flag = flag;
      end
    end else begin
      res.cnt  = reload;
      res.flag = 1'b0;
    end
    return res;
  endfunction

  cfg_t cfg;

  zcsd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Input register.
  logic in_vld_r;
  logic zc_r, triac_r, extr_r, stand_r, cart_r;

  // Sequencer state; also the result payload.
  phase_t          phase_r, phase_nxt;
  logic [CntW-1:0] settle_r, settle_nxt;
  logic [CntW-1:0] extr_cnt_r, extr_cnt_nxt;
  logic [CntW-1:0] stand_cnt_r, stand_cnt_nxt;
  logic [CntW-1:0] cart_cnt_r, cart_cnt_nxt;
  logic            extr_flag_r, extr_flag_nxt;
  logic            stand_flag_r, stand_flag_nxt;
  logic            cart_flag_r, cart_flag_nxt;
  logic            meas_en_r, meas_en_nxt;
  logic            strobe_r, strobe_nxt;
  logic            out_vld_r;

  logic            advance;
  logic            in_xfer;
  logic [CntW-1:0] settle_dec;
  deb_t            extr_res, stand_res, cart_res;

  // A captured tick moves into the state when the result slot is free or is
  // being taken in this cycle.
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      zc_r    <= in_ch.zero_cross;
      triac_r <= in_ch.triac_on;
      extr_r  <= in_ch.extractor_pin;
      stand_r <= in_ch.stand_pin;
      cart_r  <= in_ch.cartridge_pin;
    end
  end

  assign settle_dec = (settle_r != '0) ? settle_r - 1'b1 : settle_r;
  assign extr_res   = debounce(!extr_r && stand_r, extr_cnt_r,
                               cfg.extractor_debounce, extr_flag_r);
  assign stand_res  = debounce(extr_r && !stand_r, stand_cnt_r,
                               cfg.stand_debounce, stand_flag_r);
  assign cart_res   = debounce(!cart_r, cart_cnt_r,
                               cfg.cartridge_debounce, cart_flag_r);

  always_comb begin
    phase_nxt      = phase_r;
    settle_nxt     = settle_r;
    extr_cnt_nxt   = extr_cnt_r;
    stand_cnt_nxt  = stand_cnt_r;
    cart_cnt_nxt   = cart_cnt_r;
    extr_flag_nxt  = extr_flag_r;
    stand_flag_nxt = stand_flag_r;
    cart_flag_nxt  = cart_flag_r;
    meas_en_nxt    = meas_en_r;
    strobe_nxt     = strobe_r;
    unique case (phase_r)
      PH_INIT: begin
        settle_nxt = cfg.settle_ticks;
        phase_nxt  = PH_AWAIT;
      end
      PH_AWAIT: begin
        if (zc_r && !triac_r) begin
          settle_nxt = cfg.settle_ticks;
          phase_nxt  = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        settle_nxt = settle_dec;
        // A settle time of zero ends on the first tick of this phase.
        if (settle_dec == '0) begin
          meas_en_nxt = 1'b0;
          strobe_nxt  = 1'b1;
          phase_nxt   = PH_SENSE;
        end
      end
      PH_SENSE: begin
        extr_cnt_nxt   = extr_res.cnt;
        extr_flag_nxt  = extr_res.flag;
        stand_cnt_nxt  = stand_res.cnt;
        stand_flag_nxt = stand_res.flag;
        cart_cnt_nxt   = cart_res.cnt;
        cart_flag_nxt  = cart_res.flag;
        meas_en_nxt    = 1'b1;
        strobe_nxt     = 1'b0;
        phase_nxt      = PH_AWAIT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      phase_r      <= PH_INIT;
      settle_r     <= '0;
      extr_cnt_r   <= DebounceReset;
      stand_cnt_r  <= DebounceReset;
      cart_cnt_r   <= DebounceReset;
      extr_flag_r  <= 1'b0;
      stand_flag_r <= 1'b0;
      cart_flag_r  <= 1'b0;
      meas_en_r    <= 1'b1;
      strobe_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r    <= 1'b1;
        phase_r      <= phase_nxt;
        settle_r     <= settle_nxt;
        extr_cnt_r   <= extr_cnt_nxt;
        stand_cnt_r  <= stand_cnt_nxt;
        cart_cnt_r   <= cart_cnt_nxt;
        extr_flag_r  <= extr_flag_nxt;
        stand_flag_r <= stand_flag_nxt;
        cart_flag_r  <= cart_flag_nxt;
        meas_en_r    <= meas_en_nxt;
        strobe_r     <= strobe_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.extractor_flag = extr_flag_r;
  assign out_ch.stand_flag     = stand_flag_r;
  assign out_ch.cartridge_flag = cart_flag_r;
  assign out_ch.measure_enable = meas_en_r;
  assign out_ch.detect_strobe  = strobe_r;
  assign out_ch.phase_out      = phase_r;

endmodule

`default_nettype wire
